>>> hdl/bwdu_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint and watchpoint debug unit package
// Shared item types, request and cause codes, and controller commands.
// ----------------------------------------------------------------------------
package bwdu_pkg;

  localparam logic [3:0] REQ_BEFORE_INSTR = 4'd0;
  localparam logic [3:0] REQ_AFTER_INSTR  = 4'd1;
  localparam logic [3:0] REQ_MEM_READ     = 4'd2;
  localparam logic [3:0] REQ_MEM_WRITE    = 4'd3;
  localparam logic [3:0] REQ_ADD_BP       = 4'd4;
  localparam logic [3:0] REQ_REM_BP       = 4'd5;
  localparam logic [3:0] REQ_ADD_RD_WP    = 4'd6;
  localparam logic [3:0] REQ_REM_RD_WP    = 4'd7;
  localparam logic [3:0] REQ_ADD_WR_WP    = 4'd8;
  localparam logic [3:0] REQ_REM_WR_WP    = 4'd9;
  localparam logic [3:0] REQ_PAUSE        = 4'd10;
  localparam logic [3:0] REQ_CONTINUE     = 4'd11;
  localparam logic [3:0] REQ_STEP         = 4'd12;

  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_BP       = 3'd1;
  localparam logic [2:0] CAUSE_STEP     = 3'd2;
  localparam logic [2:0] CAUSE_RD_WATCH = 3'd3;
  localparam logic [2:0] CAUSE_WR_WATCH = 3'd4;
  localparam logic [2:0] CAUSE_PAUSE    = 3'd5;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic        halted;
    logic [2:0]  halt_cause;
    logic [31:0] halt_address;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rd_scan;
    logic rd_last;
    logic cmp;
    logic idx_inc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic empty;
    logic hit;
    logic idx_last;
    logic is_remove;
  } sts_t;

endpackage

>>> hdl/bwdu_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bwdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bwdu_ctrl.sv
// ----------------------------------------------------------------------------
// Debug unit controller
// Sequences one item: dispatch, table scan, entry move and final update.
// ----------------------------------------------------------------------------
module bwdu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bwdu_pkg::sts_t sts,
  output bwdu_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DISPATCH = 6'b000010,
    ST_READ     = 6'b000100,
    ST_COMPARE  = 6'b001000,
    ST_MOVE_RD  = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.need_scan && !sts.empty) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = ST_COMPARE;
      end
      ST_COMPARE: begin
        cmd.cmp = 1'b1;
        if (sts.hit) begin
          state_nxt = sts.is_remove ? ST_MOVE_RD : ST_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = sts.idx_last ? ST_FINISH : ST_READ;
        end
      end
      ST_MOVE_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> hdl/bwdu_dpath.sv
// ----------------------------------------------------------------------------
// Debug unit datapath
// Holds the three address tables, their fill counts, the halt state and the
// result register.
// ----------------------------------------------------------------------------
module bwdu_dpath #(
  parameter int BP_ENTRIES    = 16,
  parameter int WATCH_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bwdu_pkg::in_item_t  in_data,
  input  bwdu_pkg::cmd_t      cmd,
  output bwdu_pkg::sts_t      sts,
  output logic                out_valid,
  output bwdu_pkg::out_item_t out_data
);

  localparam int BP_AW  = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
  localparam int WP_AW  = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;
  localparam int BP_CW  = $clog2(BP_ENTRIES + 1);
  localparam int WP_CW  = $clog2(WATCH_ENTRIES + 1);
  localparam int MAX_E  = (BP_ENTRIES > WATCH_ENTRIES) ? BP_ENTRIES : WATCH_ENTRIES;
  localparam int CW     = $clog2(MAX_E + 1);
  localparam logic [BP_CW-1:0] BP_CAP = BP_CW'(BP_ENTRIES);
  localparam logic [WP_CW-1:0] WP_CAP = WP_CW'(WATCH_ENTRIES);

  logic [3:0]       req_r;
  logic [31:0]      addr_r;
  logic [CW-1:0]    idx_r;
  logic             found_r;
  logic [BP_CW-1:0] bp_used_r, bp_used_nxt;
  logic [WP_CW-1:0] rw_used_r, rw_used_nxt;
  logic [WP_CW-1:0] ww_used_r, ww_used_nxt;
  logic             halted_r, halted_nxt;
  logic             stepping_r, stepping_nxt;
  logic [2:0]       cause_r, cause_nxt;
  logic [31:0]      stop_addr_r, stop_addr_nxt;
  logic             skip_r, skip_nxt;
  logic [31:0]      skip_addr_r, skip_addr_nxt;
  logic             out_valid_r;
  bwdu_pkg::out_item_t out_data_r;

  logic        sel_bp, sel_rw, sel_ww;
  logic [CW-1:0] used_sel;
  logic        full_sel;
  logic [31:0] rdata_sel;
  logic [31:0] bp_rdata, rw_rdata, ww_rdata;
  logic        add_we, rem_we, ok;
  logic        do_halt;
  logic [2:0]  halt_cause;
  logic [31:0] halt_addr;
  logic        skip_hit;

  logic [BP_AW-1:0] bp_waddr, bp_raddr;
  logic [WP_AW-1:0] rw_waddr, rw_raddr, ww_waddr, ww_raddr;
  logic [31:0]      wdata;

  assign sel_bp = (req_r == bwdu_pkg::REQ_BEFORE_INSTR) || (req_r == bwdu_pkg::REQ_ADD_BP) ||
                  (req_r == bwdu_pkg::REQ_REM_BP);
  assign sel_rw = (req_r == bwdu_pkg::REQ_MEM_READ) || (req_r == bwdu_pkg::REQ_ADD_RD_WP) ||
                  (req_r == bwdu_pkg::REQ_REM_RD_WP);
  assign sel_ww = (req_r == bwdu_pkg::REQ_MEM_WRITE) || (req_r == bwdu_pkg::REQ_ADD_WR_WP) ||
                  (req_r == bwdu_pkg::REQ_REM_WR_WP);

  always_comb begin
    used_sel  = '0;
    full_sel  = 1'b0;
    rdata_sel = ww_rdata;
    if (sel_bp) begin
      used_sel  = CW'(bp_used_r);
      full_sel  = (bp_used_r == BP_CAP);
      rdata_sel = bp_rdata;
    end else if (sel_rw) begin
      used_sel  = CW'(rw_used_r);
      full_sel  = (rw_used_r == WP_CAP);
      rdata_sel = rw_rdata;
    end else if (sel_ww) begin
      used_sel  = CW'(ww_used_r);
      full_sel  = (ww_used_r == WP_CAP);
    end
  end

  assign skip_hit = skip_r && (skip_addr_r == addr_r);

  always_comb begin
    case (req_r) inside
      bwdu_pkg::REQ_BEFORE_INSTR: sts.need_scan = !halted_r && !skip_hit;
      bwdu_pkg::REQ_MEM_READ, bwdu_pkg::REQ_MEM_WRITE,
      bwdu_pkg::REQ_ADD_BP, bwdu_pkg::REQ_REM_BP,
      bwdu_pkg::REQ_ADD_RD_WP, bwdu_pkg::REQ_REM_RD_WP,
      bwdu_pkg::REQ_ADD_WR_WP, bwdu_pkg::REQ_REM_WR_WP: sts.need_scan = 1'b1;
      default: sts.need_scan = 1'b0;
    endcase
    sts.empty     = (used_sel == '0);
    sts.hit       = (rdata_sel == addr_r);
    sts.idx_last  = (({1'b0, idx_r} + 1'b1) == {1'b0, used_sel});
    sts.is_remove = (req_r == bwdu_pkg::REQ_REM_BP) || (req_r == bwdu_pkg::REQ_REM_RD_WP) ||
                    (req_r == bwdu_pkg::REQ_REM_WR_WP);
  end

  always_comb begin
    halted_nxt    = halted_r;
    stepping_nxt  = stepping_r;
    cause_nxt     = cause_r;
    stop_addr_nxt = stop_addr_r;
    skip_nxt      = skip_r;
    skip_addr_nxt = skip_addr_r;
    ok            = 1'b1;
    add_we        = 1'b0;
    rem_we        = 1'b0;
    do_halt       = 1'b0;
    halt_cause    = bwdu_pkg::CAUSE_NONE;
    halt_addr     = addr_r;
    if (cmd.finish) begin
      case (req_r) inside
        bwdu_pkg::REQ_BEFORE_INSTR: begin
          if (halted_r) begin
            ok = 1'b0;
          end else begin
            skip_nxt = 1'b0;
            if (found_r) begin
              do_halt    = 1'b1;
              halt_cause = bwdu_pkg::CAUSE_BP;
              ok         = 1'b0;
            end
          end
        end
        bwdu_pkg::REQ_AFTER_INSTR: begin
          if (stepping_r && !halted_r) begin
            do_halt    = 1'b1;
            halt_cause = bwdu_pkg::CAUSE_STEP;
          end
        end
        bwdu_pkg::REQ_MEM_READ: begin
          do_halt    = found_r;
          halt_cause = bwdu_pkg::CAUSE_RD_WATCH;
        end
        bwdu_pkg::REQ_MEM_WRITE: begin
          do_halt    = found_r;
          halt_cause = bwdu_pkg::CAUSE_WR_WATCH;
        end
        bwdu_pkg::REQ_ADD_BP, bwdu_pkg::REQ_ADD_RD_WP, bwdu_pkg::REQ_ADD_WR_WP: begin
          if (!found_r) begin
            ok     = !full_sel;
            add_we = !full_sel;
          end
        end
        bwdu_pkg::REQ_REM_BP, bwdu_pkg::REQ_REM_RD_WP, bwdu_pkg::REQ_REM_WR_WP: begin
          ok     = found_r;
          rem_we = found_r;
        end
        bwdu_pkg::REQ_PAUSE: begin
          do_halt    = 1'b1;
          halt_cause = bwdu_pkg::CAUSE_PAUSE;
          halt_addr  = '0;
        end
        bwdu_pkg::REQ_CONTINUE, bwdu_pkg::REQ_STEP: begin
          skip_nxt      = (cause_r == bwdu_pkg::CAUSE_BP);
          skip_addr_nxt = stop_addr_r;
          halted_nxt    = 1'b0;
          stepping_nxt  = (req_r == bwdu_pkg::REQ_STEP);
          cause_nxt     = bwdu_pkg::CAUSE_NONE;
        end
        default: begin
          ok = 1'b1;
        end
      endcase
      if (do_halt) begin
        halted_nxt    = 1'b1;
        stepping_nxt  = 1'b0;
        cause_nxt     = halt_cause;
        stop_addr_nxt = halt_addr;
      end
    end
  end

  always_comb begin
    bp_used_nxt = bp_used_r;
    rw_used_nxt = rw_used_r;
    ww_used_nxt = ww_used_r;
    if (add_we) begin
      if (sel_bp) bp_used_nxt = bp_used_r + 1'b1;
      if (sel_rw) rw_used_nxt = rw_used_r + 1'b1;
      if (sel_ww) ww_used_nxt = ww_used_r + 1'b1;
    end else if (rem_we) begin
      if (sel_bp) bp_used_nxt = bp_used_r - 1'b1;
      if (sel_rw) rw_used_nxt = rw_used_r - 1'b1;
      if (sel_ww) ww_used_nxt = ww_used_r - 1'b1;
    end
  end

  assign wdata = add_we ? addr_r : rdata_sel;

  always_comb begin
    bp_waddr = add_we ? bp_used_r[BP_AW-1:0] : idx_r[BP_AW-1:0];
    rw_waddr = add_we ? rw_used_r[WP_AW-1:0] : idx_r[WP_AW-1:0];
    ww_waddr = add_we ? ww_used_r[WP_AW-1:0] : idx_r[WP_AW-1:0];
    bp_raddr = idx_r[BP_AW-1:0];
    rw_raddr = idx_r[WP_AW-1:0];
    ww_raddr = idx_r[WP_AW-1:0];
    if (cmd.rd_last) begin
      bp_raddr = BP_AW'(bp_used_r - 1'b1);
      rw_raddr = WP_AW'(rw_used_r - 1'b1);
      ww_raddr = WP_AW'(ww_used_r - 1'b1);
    end
  end

  bwdu_ram #(.WIDTH(32), .DEPTH(BP_ENTRIES)) u_bp_ram (
    .clk   (clk),
    .we    ((add_we || rem_we) && sel_bp),
    .waddr (bp_waddr),
    .wdata (wdata),
    .re    ((cmd.rd_scan || cmd.rd_last) && sel_bp),
    .raddr (bp_raddr),
    .rdata (bp_rdata)
  );

  bwdu_ram #(.WIDTH(32), .DEPTH(WATCH_ENTRIES)) u_rw_ram (
    .clk   (clk),
    .we    ((add_we || rem_we) && sel_rw),
    .waddr (rw_waddr),
    .wdata (wdata),
    .re    ((cmd.rd_scan || cmd.rd_last) && sel_rw),
    .raddr (rw_raddr),
    .rdata (rw_rdata)
  );

  bwdu_ram #(.WIDTH(32), .DEPTH(WATCH_ENTRIES)) u_ww_ram (
    .clk   (clk),
    .we    ((add_we || rem_we) && sel_ww),
    .waddr (ww_waddr),
    .wdata (wdata),
    .re    ((cmd.rd_scan || cmd.rd_last) && sel_ww),
    .raddr (ww_raddr),
    .rdata (ww_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_data.req_type;
      addr_r <= in_data.address;
    end
    if (cmd.finish) begin
      out_data_r.ok           <= ok;
      out_data_r.halted       <= halted_nxt;
      out_data_r.halt_cause   <= cause_nxt;
      out_data_r.halt_address <= stop_addr_nxt;
    end
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      bp_used_r   <= '0;
      rw_used_r   <= '0;
      ww_used_r   <= '0;
      halted_r    <= 1'b0;
      stepping_r  <= 1'b0;
      cause_r     <= bwdu_pkg::CAUSE_NONE;
      stop_addr_r <= '0;
      skip_r      <= 1'b0;
      skip_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (cmd.cmp && sts.hit) begin
        found_r <= 1'b1;
      end
      bp_used_r   <= bp_used_nxt;
      rw_used_r   <= rw_used_nxt;
      ww_used_r   <= ww_used_nxt;
      halted_r    <= halted_nxt;
      stepping_r  <= stepping_nxt;
      cause_r     <= cause_nxt;
      stop_addr_r <= stop_addr_nxt;
      skip_r      <= skip_nxt;
      skip_addr_r <= skip_addr_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/breakpoint_watchpoint_debug_unit.sv
// ----------------------------------------------------------------------------
// Breakpoint and watchpoint debug unit
// Keeps breakpoint, read watchpoint and write watchpoint address tables and
// the halt state of a debugged processor.
//
// An item (request type and address) transfers at a rising edge with start
// high and busy low. Busy stays high until the item is done. Its result
// appears on out_data for exactly one cycle with out_valid high; the
// receiver cannot hold it off, and it must sample the result in that cycle.
//
// Table requests and watched events scan the selected table one entry at a
// time through its RAM, reading and then comparing each entry, and stop at
// the first match. A removal that finds its address also reads the last
// entry to move it into the freed slot. A new item can transfer in the
// cycle the previous result is shown.
//
// After reset all tables are empty, the unit runs (not halted) with no
// cause and no recorded address. Table contents need no clearing pass.
// ----------------------------------------------------------------------------
module breakpoint_watchpoint_debug_unit #(
  parameter int BP_ENTRIES    = 16,
  parameter int WATCH_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bwdu_pkg::in_item_t  in_data,
  output logic                out_valid,
  output bwdu_pkg::out_item_t out_data
);

  bwdu_pkg::cmd_t cmd;
  bwdu_pkg::sts_t sts;

  bwdu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bwdu_dpath #(
    .BP_ENTRIES    (BP_ENTRIES),
    .WATCH_ENTRIES (WATCH_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
